@@ rtl/dvfs_pbg_pkg.sv @@
// ----------------------------------------------------------------------------
// dvfs_pbg_pkg
// Shared types and constants of the power-budget governor: request codes,
// payload widths and the request and response item layouts.
// ----------------------------------------------------------------------------
package dvfs_pbg_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_TABLE_WRITE  = 2'd0;
  localparam logic [1:0] REQ_CLAMP_UPDATE = 2'd1;
  localparam logic [1:0] REQ_PERF_REDUCE  = 2'd2;
  localparam logic [1:0] REQ_PERF_BOOST   = 2'd3;

  localparam int unsigned POWER_W = 30;  // table entry width
  localparam int unsigned CLAMP_W = 32;  // clamp and summed power width
  localparam int unsigned LEVEL_W = 4;   // level index width on the ports
  // Accumulator for up to 16 table entries, wide enough to detect overflow
  localparam int unsigned ACC_W   = 34;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [1:0]         domain;
    logic [LEVEL_W-1:0] level_index;
    logic [POWER_W-1:0] level_power;
    logic [CLAMP_W-1:0] clamp_value;
    logic               grant;
  } req_t;

  typedef struct packed {
    logic               boost_request;
    logic [CLAMP_W-1:0] requested_power;
    logic               boost_ready;
    logic [LEVEL_W-1:0] ceiling_level;
    logic [LEVEL_W-1:0] floor_level_a;
    logic [LEVEL_W-1:0] floor_level_b;
    logic [LEVEL_W-1:0] floor_level_c;
    logic [LEVEL_W-1:0] floor_level_d;
  } rsp_t;

endpackage

@@ rtl/dvfs_pbg_req_if.sv @@
// ----------------------------------------------------------------------------
// dvfs_pbg_req_if
// Request channel: valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface dvfs_pbg_req_if;
  logic               valid;
  logic               ready;
  dvfs_pbg_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/dvfs_pbg_rsp_if.sv @@
// ----------------------------------------------------------------------------
// dvfs_pbg_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface dvfs_pbg_rsp_if;
  logic               valid;
  logic               ready;
  dvfs_pbg_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/dvfs_pbg_ram.sv @@
// ----------------------------------------------------------------------------
// dvfs_pbg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dvfs_pbg_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/dvfs_power_budget_governor.sv @@
// ----------------------------------------------------------------------------
// dvfs_power_budget_governor
// Power-budget governor for a set of DVFS domains: per-domain power tables,
// a shared ceiling level, per-domain floor levels and a power clamp.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request item per handshake: table write, clamp update,
//   perf reduce or perf boost. rsp returns exactly one result item for each
//   request: the boost request flag and power, the ready flag, the ceiling
//   and the four floor levels as they stand after the item.
//   A table write or a reduce goes to the finish step, which loads the result
//   register; a boost that sums first reads one entry per domain. A clamp
//   update sums the ceiling entries, searches domain 0's table up to the
//   first entry above the clamp and then loads the result. The table RAM's
//   read port gives one entry per cycle. req is ready again in the cycle
//   after the result loads.
//   Reset sets the ceiling to NUM_LEVELS-1, floors, clamp and ready flag to 0;
//   the table RAM is not cleared and must be written before it is read.
//   A stalled result holds in the output register; the next request is still
//   accepted and worked on, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module dvfs_power_budget_governor #(
  parameter int unsigned NUM_DOMAINS = 4,
  parameter int unsigned NUM_LEVELS  = 16
) (
  input  logic          clk,
  input  logic          rst,
  dvfs_pbg_req_if.sink   req,
  dvfs_pbg_rsp_if.source rsp
);

  // Domain and level index widths; the table address is {domain, level}
  localparam int unsigned DomW    = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;
  localparam int unsigned LvlW    = $clog2(NUM_LEVELS);
  localparam int unsigned AddrW   = DomW + LvlW;
  localparam int unsigned Depth   = 1 << AddrW;
  localparam int unsigned MaxCnt  = (NUM_DOMAINS > NUM_LEVELS) ? NUM_DOMAINS : NUM_LEVELS;
  localparam int unsigned CntW    = $clog2(MaxCnt + 1);
  localparam int unsigned PowerW  = dvfs_pbg_pkg::POWER_W;
  localparam int unsigned ClampW  = dvfs_pbg_pkg::CLAMP_W;
  localparam int unsigned AccW    = dvfs_pbg_pkg::ACC_W;
  localparam int unsigned OutLvlW = dvfs_pbg_pkg::LEVEL_W;
  localparam logic [LvlW-1:0] TopLevel = LvlW'(NUM_LEVELS - 1);

  typedef enum logic [1:0] {
    S_IDLE,    // wait for a request
    S_SUM,     // stream one entry per domain into the accumulator
    S_SCAN,    // search domain 0's table for the new ceiling
    S_FINISH   // move the result into the output register
  } state_t;

  state_t              state;
  logic [1:0]          kind;
  logic [ClampW-1:0]   clamp_in;
  logic                grant_in;
  logic [LvlW-1:0]     sum_lvl;
  logic [LvlW-1:0]     ceiling;
  logic [LvlW-1:0]     floors [NUM_DOMAINS];
  logic [ClampW-1:0]   cur_clamp;
  logic                ready_flag;
  logic [ClampW-1:0]   budget;
  logic [CntW-1:0]     issue_cnt;
  logic                pend;
  logic                pend_last;
  logic [LvlW-1:0]     pend_idx;
  logic [AccW-1:0]     acc;
  logic                req_flag;
  logic [ClampW-1:0]   req_pow;
  logic                out_valid;
  dvfs_pbg_pkg::rsp_t  out_data;

  // Table RAM ports
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic [AddrW-1:0]    rd_addr;
  logic [PowerW-1:0]   rd_data;

  logic                accept;
  logic                dom_ok;
  logic [DomW-1:0]     dom_idx;
  logic                issue;
  logic [AccW-1:0]     acc_sum;
  logic [ClampW-1:0]   acc_sat;
  logic                scan_hit;
  logic [LvlW-1:0]     hit_level;
  logic [LvlW-1:0]     new_floor;
  logic [OutLvlW-1:0]  floor_out [4];

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign dom_ok  = 32'(req.data.domain) < NUM_DOMAINS;
  assign dom_idx = DomW'(req.data.domain);

  // Table writes go straight to the RAM at acceptance
  assign wr_en   = accept && (req.data.req_type == dvfs_pbg_pkg::REQ_TABLE_WRITE) && dom_ok
                   && (32'(req.data.level_index) < NUM_LEVELS);
  assign wr_addr = {dom_idx, LvlW'(req.data.level_index)};

  // One read issued per cycle while entries remain
  always_comb begin
    issue   = 1'b0;
    rd_addr = '0;
    case (state)
      S_SUM: begin
        issue   = 32'(issue_cnt) < NUM_DOMAINS;
        rd_addr = {issue_cnt[DomW-1:0], sum_lvl};
      end
      S_SCAN: begin
        issue   = 32'(issue_cnt) < NUM_LEVELS;
        rd_addr = {DomW'(0), issue_cnt[LvlW-1:0]};
      end
      default: begin
        issue   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  dvfs_pbg_ram #(
    .WIDTH (PowerW),
    .DEPTH (Depth)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.data.level_power),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Running sum including the entry arriving now, saturated to the clamp width
  assign acc_sum   = acc + AccW'(rd_data);
  assign acc_sat   = (acc_sum[AccW-1:ClampW] != '0) ? '1 : acc_sum[ClampW-1:0];
  assign scan_hit  = ClampW'(rd_data) > clamp_in;
  assign hit_level = (pend_idx == '0) ? '0 : pend_idx - LvlW'(1);

  // Floors drop to one below the level being taken as ceiling
  always_comb begin
    if (scan_hit) begin
      new_floor = (hit_level == '0) ? '0 : hit_level - LvlW'(1);
    end else begin
      new_floor = TopLevel - LvlW'(1);
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (j < NUM_DOMAINS) begin
        floor_out[j] = OutLvlW'(floors[j % NUM_DOMAINS]);
      end else begin
        floor_out[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ceiling    <= TopLevel;
      for (int d = 0; d < NUM_DOMAINS; d++) begin
        floors[d] <= '0;
      end
      cur_clamp  <= '0;
      ready_flag <= 1'b0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Drop the result once the sink takes it; the finish step reloads it
      if (out_valid && rsp.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            kind      <= req.data.req_type;
            clamp_in  <= req.data.clamp_value;
            grant_in  <= req.data.grant;
            req_flag  <= 1'b0;
            req_pow   <= '0;
            acc       <= '0;
            issue_cnt <= '0;
            pend      <= 1'b0;
            case (req.data.req_type)
              dvfs_pbg_pkg::REQ_CLAMP_UPDATE: begin
                sum_lvl <= ceiling;
                state   <= S_SUM;
              end
              dvfs_pbg_pkg::REQ_PERF_REDUCE: begin
                if (dom_ok && floors[dom_idx] != '0) begin
                  floors[dom_idx] <= floors[dom_idx] - LvlW'(1);
                end
                state <= S_FINISH;
              end
              dvfs_pbg_pkg::REQ_PERF_BOOST: begin
                if (dom_ok && ceiling != TopLevel) begin
                  sum_lvl <= ceiling + LvlW'(1);
                  state   <= S_SUM;
                end else begin
                  state <= S_FINISH;
                end
              end
              default: begin
                // table write already went to the RAM
                state <= S_FINISH;
              end
            endcase
          end
        end

        S_SUM: begin
          if (issue) begin
            issue_cnt <= issue_cnt + CntW'(1);
            pend_last <= 32'(issue_cnt) == NUM_DOMAINS - 1;
          end
          pend <= issue;
          if (pend) begin
            acc <= acc_sum;
            if (pend_last) begin
              issue_cnt <= '0;
              if (kind == dvfs_pbg_pkg::REQ_CLAMP_UPDATE) begin
                budget <= acc_sat;
                state  <= S_SCAN;
              end else begin
                if (acc_sat > cur_clamp) begin
                  req_flag   <= 1'b1;
                  req_pow    <= acc_sat;
                  ready_flag <= 1'b0;
                end
                state <= S_FINISH;
              end
            end
          end
        end

        S_SCAN: begin
          if (issue) begin
            issue_cnt <= issue_cnt + CntW'(1);
            pend_idx  <= issue_cnt[LvlW-1:0];
            pend_last <= 32'(issue_cnt) == NUM_LEVELS - 1;
          end
          if (pend && (scan_hit || pend_last)) begin
            // First entry above the clamp sets the ceiling one below it
            pend       <= 1'b0;
            ceiling    <= scan_hit ? hit_level : TopLevel;
            cur_clamp  <= clamp_in;
            ready_flag <= grant_in;
            if (budget > clamp_in && floors[0] > (scan_hit ? hit_level : TopLevel)) begin
              for (int d = 0; d < NUM_DOMAINS; d++) begin
                floors[d] <= new_floor;
              end
            end
            state <= S_FINISH;
          end else begin
            pend <= issue;
          end
        end

        S_FINISH: begin
          // Hold here until the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid                <= 1'b1;
            out_data.boost_request   <= req_flag;
            out_data.requested_power <= req_pow;
            out_data.boost_ready     <= ready_flag;
            out_data.ceiling_level   <= OutLvlW'(ceiling);
            out_data.floor_level_a   <= floor_out[0];
            out_data.floor_level_b   <= floor_out[1];
            out_data.floor_level_c   <= floor_out[2];
            out_data.floor_level_d   <= floor_out[3];
            state                    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/tb_dvfs_power_budget_governor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dvfs_power_budget_governor
// Self-checking bench for the power-budget governor. A short directed table
// covers reset state, the clamp search extremes and boosts at the top level.
// A random phase of shaped table writes, clamp updates near table entries,
// reduces and boosts follows. Every result item is compared against a typed
// row or an in-bench governor model, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_dvfs_power_budget_governor;

  localparam int unsigned POWER_W    = dvfs_pbg_pkg::POWER_W;
  localparam int unsigned CLAMP_W    = dvfs_pbg_pkg::CLAMP_W;
  localparam int unsigned LEVEL_W    = dvfs_pbg_pkg::LEVEL_W;
  localparam int unsigned ACC_W      = dvfs_pbg_pkg::ACC_W;
  localparam int unsigned N_DOM      = 4;
  localparam int unsigned N_LVL      = 16;
  localparam int unsigned RAND_ITEMS = 712;
  localparam int unsigned HOLD_CYC   = 300;   // long receiver hold-off
  localparam int unsigned DRAIN_CYC  = 30;    // above the worst clamp latency
  localparam int unsigned STEP       = 4096;  // preload power step
  localparam int unsigned LIMIT_NS   = 5_000_000;

  typedef dvfs_pbg_pkg::req_t req_t;
  typedef dvfs_pbg_pkg::rsp_t rsp_t;

  typedef struct {
    req_t item;
    bit   typed;   // expectation typed in the row, not predicted
    rsp_t want;
  } plan_row_t;

  logic clk;
  logic rst;

  dvfs_pbg_req_if req_if ();
  dvfs_pbg_rsp_if rsp_if ();

  dvfs_power_budget_governor #(
    .NUM_DOMAINS(N_DOM),
    .NUM_LEVELS (N_LVL)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // Governor model state
  logic [POWER_W-1:0] power_tbl [N_DOM][N_LVL];
  logic [LEVEL_W-1:0] ceil_lvl  [N_DOM];
  logic [LEVEL_W-1:0] floor_lvl [N_DOM];
  logic [CLAMP_W-1:0] clamp_reg;
  logic               boost_ok;

  rsp_t      status_due [$];   // results owed by the block, oldest first
  plan_row_t plan [$];
  int        fail_count;
  bit        calm;             // suppress idling on both sides
  bit        hold_trigger;     // ask the receiver for a long hold-off

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // Sum every domain's power at ceiling + offset, saturating at 32 bits.
  function automatic logic [CLAMP_W-1:0] level_sum(int unsigned offset);
    logic [ACC_W-1:0] acc;
    int unsigned      lvl;
    acc = '0;
    for (int d = 0; d < N_DOM; d++) begin
      lvl = ceil_lvl[d] + offset;
      if (lvl < N_LVL) acc += power_tbl[d][lvl];
    end
    return (acc > ACC_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : acc[CLAMP_W-1:0];
  endfunction

  // One below domain 0's first entry above the clamp, at least 0; top if none.
  function automatic logic [LEVEL_W-1:0] ceiling_for(logic [CLAMP_W-1:0] clamp);
    for (int i = 0; i < N_LVL; i++) begin
      if (CLAMP_W'(power_tbl[0][i]) > clamp) return (i > 0) ? LEVEL_W'(i - 1) : '0;
    end
    return LEVEL_W'(N_LVL - 1);
  endfunction

  function automatic rsp_t predict_governor(req_t item);
    rsp_t               res;
    logic [CLAMP_W-1:0] budget;
    logic [CLAMP_W-1:0] total;
    logic [LEVEL_W-1:0] idx;
    res = '0;
    case (item.req_type)
      dvfs_pbg_pkg::REQ_TABLE_WRITE: begin
        power_tbl[item.domain][item.level_index] = item.level_power;
      end
      dvfs_pbg_pkg::REQ_CLAMP_UPDATE: begin
        clamp_reg = item.clamp_value;
        boost_ok  = item.grant;
        budget    = level_sum(0);
        idx       = ceiling_for(item.clamp_value);
        for (int d = 0; d < N_DOM; d++) ceil_lvl[d] = idx;
        // Only domain 0's floor is tested; all floors move together.
        if (budget > item.clamp_value && floor_lvl[0] > idx) begin
          for (int d = 0; d < N_DOM; d++) floor_lvl[d] = (idx > 0) ? idx - 1'b1 : '0;
        end
      end
      dvfs_pbg_pkg::REQ_PERF_REDUCE: begin
        if (floor_lvl[item.domain] > 0) floor_lvl[item.domain] -= 1'b1;
      end
      dvfs_pbg_pkg::REQ_PERF_BOOST: begin
        if (ceil_lvl[item.domain] < N_LVL - 1) begin
          total = level_sum(1);
          if (total > clamp_reg) begin
            res.boost_request   = 1'b1;
            res.requested_power = total;
            boost_ok            = 1'b0;
          end
        end
      end
      default: ;
    endcase
    res.boost_ready   = boost_ok;
    res.ceiling_level = ceil_lvl[0];
    res.floor_level_a = floor_lvl[0];
    res.floor_level_b = floor_lvl[1];
    res.floor_level_c = floor_lvl[2];
    res.floor_level_d = floor_lvl[3];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic req_t mk_item(logic [1:0] kind, logic [1:0] dom,
                                   logic [LEVEL_W-1:0] lvl, logic [POWER_W-1:0] pwr,
                                   logic [CLAMP_W-1:0] clamp, logic grant);
    req_t it;
    it.req_type    = kind;
    it.domain      = dom;
    it.level_index = lvl;
    it.level_power = pwr;
    it.clamp_value = clamp;
    it.grant       = grant;
    return it;
  endfunction

  // Status with no request and all floors at zero.
  function automatic rsp_t quiet_status(logic ready, logic [LEVEL_W-1:0] ceil);
    rsp_t r;
    r = '0;
    r.boost_ready   = ready;
    r.ceiling_level = ceil;
    return r;
  endfunction

  function automatic void add_row(req_t item, bit typed = 1'b0, rsp_t want = '0);
    plan_row_t row;
    row.item  = item;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  function automatic req_t random_item();
    req_t        it;
    int unsigned pick;
    int unsigned lvl;
    // Randomize every field, then shape the ones the operation uses.
    it.req_type    = 2'($urandom);
    it.domain      = 2'($urandom);
    it.level_index = LEVEL_W'($urandom);
    it.level_power = POWER_W'($urandom);
    it.clamp_value = $urandom;
    it.grant       = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 30) begin
      it.req_type = dvfs_pbg_pkg::REQ_TABLE_WRITE;
      // Mostly rising with level so the clamp search lands mid-table.
      if ($urandom_range(99) < 70) begin
        it.level_power = POWER_W'((it.level_index + 1) * (1 << 22) + $urandom_range((1 << 22) - 1));
      end
    end else if (pick < 55) begin
      it.req_type = dvfs_pbg_pkg::REQ_CLAMP_UPDATE;
      pick = $urandom_range(99);
      if (pick < 60) begin
        lvl = $urandom_range(N_LVL - 1);
        it.clamp_value = CLAMP_W'(power_tbl[0][lvl]) + $urandom_range(2) - 1;
      end else if (pick < 80) begin
        it.clamp_value = $urandom;
      end else if (pick < 90) begin
        it.clamp_value = '0;
      end else begin
        it.clamp_value = 32'hFFFF_FFFF;
      end
    end else if (pick < 70) begin
      it.req_type = dvfs_pbg_pkg::REQ_PERF_REDUCE;
    end else begin
      it.req_type = dvfs_pbg_pkg::REQ_PERF_BOOST;
    end
    return it;
  endfunction

  // Offer one item, hold it until accepted, then record what it must return.
  // Called at a rising edge; returns at the edge that accepted the item.
  task automatic send_item(req_t item, bit typed, rsp_t want);
    bit   taken;
    rsp_t pred;
    while (!calm && $urandom_range(99) < 27) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    // Sample ready at the falling edge, where it is settled for the next edge.
    do begin
      @(negedge clk);
      taken = req_if.ready;
      @(posedge clk);
    end while (!taken);
    pred = predict_governor(item);
    status_due.push_back(typed ? want : pred);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready, with one long hold-off counted here
  // --------------------------------------------------------------------------
  initial begin : rsp_drive
    int unsigned hold_left;
    bit          hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_trigger && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        // Hold off so the block fills and backs up its input.
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= calm || ($urandom_range(99) >= 27);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each accepted result with the oldest expectation
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [CLAMP_W-1:0] want,
                                      logic [CLAMP_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(negedge clk) begin : rsp_check
    rsp_t want;
    rsp_t got;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got = rsp_if.data;
      if (status_due.size() == 0) begin
        $error("result item with no expectation pending");
        fail_count++;
      end else begin
        want = status_due.pop_front();
        check_field("boost_request",   want.boost_request,   got.boost_request);
        check_field("requested_power", want.requested_power, got.requested_power);
        check_field("boost_ready",     want.boost_ready,     got.boost_ready);
        check_field("ceiling_level",   want.ceiling_level,   got.ceiling_level);
        check_field("floor_level_a",   want.floor_level_a,   got.floor_level_a);
        check_field("floor_level_b",   want.floor_level_b,   got.floor_level_b);
        check_field("floor_level_c",   want.floor_level_c,   got.floor_level_c);
        check_field("floor_level_d",   want.floor_level_d,   got.floor_level_d);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    fail_count   = 0;
    calm         = 1'b0;
    hold_trigger <= 1'b0;
    rst          <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;

    // Model reset state; the model table is zeroed until the preload writes it.
    for (int d = 0; d < N_DOM; d++) begin
      ceil_lvl[d]  = LEVEL_W'(N_LVL - 1);
      floor_lvl[d] = '0;
      for (int l = 0; l < N_LVL; l++) power_tbl[d][l] = '0;
    end
    clamp_reg = '0;
    boost_ok  = 1'b0;

    // Right after reset: nothing reads the table yet. A reduce at floor 0
    // stays at 0, and a boost at the top level does nothing.
    add_row(mk_item(dvfs_pbg_pkg::REQ_PERF_REDUCE, 2'd0, '0, '0, '0, 1'b0), 1'b1,
            quiet_status(1'b0, 4'd15));
    add_row(mk_item(dvfs_pbg_pkg::REQ_PERF_BOOST,  2'd3, '0, '0, '0, 1'b0), 1'b1,
            quiet_status(1'b0, 4'd15));
    add_row(mk_item(dvfs_pbg_pkg::REQ_PERF_REDUCE, 2'd3, '0, '0, '0, 1'b0), 1'b1,
            quiet_status(1'b0, 4'd15));

    // Fill every table entry before any clamp update or boost reads one.
    for (int d = 0; d < N_DOM; d++) begin
      for (int l = 0; l < N_LVL; l++) begin
        add_row(mk_item(dvfs_pbg_pkg::REQ_TABLE_WRITE, 2'(d), LEVEL_W'(l),
                        POWER_W'((l + 1) * (d + 1) * STEP), '0, 1'b0));
      end
    end

    // Clamp below the first entry: ceiling drops to 0.
    add_row(mk_item(dvfs_pbg_pkg::REQ_TABLE_WRITE, 2'd0, 4'd0, 30'h3FFF_FFFF, '0, 1'b0));
    add_row(mk_item(dvfs_pbg_pkg::REQ_CLAMP_UPDATE, 2'd0, '0, '0, 32'd100, 1'b1), 1'b1,
            quiet_status(1'b1, 4'd0));
    add_row(mk_item(dvfs_pbg_pkg::REQ_PERF_BOOST, 2'd1, '0, '0, '0, 1'b0));
    // Clamp above every entry: ceiling goes to the top, boost does nothing.
    add_row(mk_item(dvfs_pbg_pkg::REQ_TABLE_WRITE, 2'd0, 4'd0, 30'h0, '0, 1'b0));
    add_row(mk_item(dvfs_pbg_pkg::REQ_CLAMP_UPDATE, 2'd0, '0, '0, 32'hFFFF_FFFF, 1'b0), 1'b1,
            quiet_status(1'b0, 4'd15));
    add_row(mk_item(dvfs_pbg_pkg::REQ_PERF_BOOST, 2'd2, '0, '0, '0, 1'b0), 1'b1,
            quiet_status(1'b0, 4'd15));
    // Zero clamp with entry 0 equal to it: ceiling 0 from the second entry.
    add_row(mk_item(dvfs_pbg_pkg::REQ_CLAMP_UPDATE, 2'd0, '0, '0, 32'd0, 1'b1), 1'b1,
            quiet_status(1'b1, 4'd0));
    add_row(mk_item(dvfs_pbg_pkg::REQ_PERF_BOOST, 2'd0, '0, '0, '0, 1'b0));
    // Mid-table clamp, then boost and reduce from there.
    add_row(mk_item(dvfs_pbg_pkg::REQ_CLAMP_UPDATE, 2'd0, '0, '0, 32'(8 * STEP), 1'b1));
    add_row(mk_item(dvfs_pbg_pkg::REQ_PERF_BOOST, 2'd3, '0, '0, '0, 1'b0));
    add_row(mk_item(dvfs_pbg_pkg::REQ_PERF_REDUCE, 2'd1, '0, '0, '0, 1'b0));
    // Top entries at full scale, then a boost into them for a large sum.
    add_row(mk_item(dvfs_pbg_pkg::REQ_TABLE_WRITE, 2'd1, 4'd15, 30'h3FFF_FFFF, '0, 1'b0));
    add_row(mk_item(dvfs_pbg_pkg::REQ_TABLE_WRITE, 2'd2, 4'd15, 30'h3FFF_FFFF, '0, 1'b0));
    add_row(mk_item(dvfs_pbg_pkg::REQ_TABLE_WRITE, 2'd3, 4'd15, 30'h3FFF_FFFF, '0, 1'b0));
    add_row(mk_item(dvfs_pbg_pkg::REQ_CLAMP_UPDATE, 2'd0, '0, '0, 32'(15 * STEP), 1'b1));
    add_row(mk_item(dvfs_pbg_pkg::REQ_PERF_BOOST, 2'd0, '0, '0, '0, 1'b0));
    // Alternating bit patterns through the power and clamp fields.
    add_row(mk_item(dvfs_pbg_pkg::REQ_TABLE_WRITE, 2'd2, 4'd5, 30'h1555_5555, '0, 1'b0));
    add_row(mk_item(dvfs_pbg_pkg::REQ_TABLE_WRITE, 2'd1, 4'd10, 30'h2AAA_AAAA, '0, 1'b0));
    add_row(mk_item(dvfs_pbg_pkg::REQ_CLAMP_UPDATE, 2'd0, '0, '0, 32'hAAAA_AAAA, 1'b0));
    add_row(mk_item(dvfs_pbg_pkg::REQ_CLAMP_UPDATE, 2'd0, '0, '0, 32'h5555_5555, 1'b1));
    add_row(mk_item(dvfs_pbg_pkg::REQ_PERF_BOOST, 2'd2, '0, '0, '0, 1'b0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].want);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // Stall the receiver once while items keep coming.
      if (n == 150) hold_trigger <= 1'b1;
      // Pause the sender once until every result is back.
      if (n == 300) begin
        req_if.valid <= 1'b0;
        do @(posedge clk); while (status_due.size() != 0);
      end
      calm = (n >= 400 && n < 550);
      send_item(random_item(), 1'b0, '0);
    end
    calm = 1'b0;
    req_if.valid <= 1'b0;

    // Drain, then give stray results time to show up.
    do @(posedge clk); while (status_due.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);

    if (fail_count == 0) begin
      $display("dvfs_power_budget_governor verification clean");
    end else begin
      $display("dvfs_power_budget_governor verification failed");
    end
    $finish;
  end

  // Hard stop if the handshakes hang.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("dvfs_power_budget_governor verification failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/dvfs_pbg_pkg.sv
rtl/dvfs_pbg_req_if.sv
rtl/dvfs_pbg_rsp_if.sv
rtl/dvfs_pbg_ram.sv
rtl/dvfs_power_budget_governor.sv
tb/tb_dvfs_power_budget_governor.sv
